[src/ntfd_pkg.sv]
// ----------------------------------------------------------------------------
// ntfd_pkg: shared types and constants for the nested TLV frame detector
// Item structs, one-hot state encodings, tag codes and status codes.
// ----------------------------------------------------------------------------
package ntfd_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
  } in_item_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADTAG = 2'd1,
    ST_DEEP   = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] frame_bytes;
  } out_item_t;

  // parse phase of the byte stream
  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_COMP    = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_t;

  // control sequencer
  typedef enum logic [2:0] {
    CTL_IDLE = 3'b001,
    CTL_POP  = 3'b010,
    CTL_EMIT = 3'b100
  } ctl_t;

  localparam logic [7:0] TAG_BLOB   = 8'h01;
  localparam logic [7:0] TAG_NODE   = 8'h02;
  localparam logic [7:0] TAG_TEXT   = 8'h03;
  localparam logic [7:0] TAG_NUMBER = 8'h04;

  localparam logic [7:0]  VARINT_MORE = 8'h80;
  localparam logic [31:0] FRAME_MAX   = 32'hFFFF_FFFF;

endpackage

[src/ntfd_ram.sv]
// ----------------------------------------------------------------------------
// ntfd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module ntfd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ntfd_varint.sv]
// ----------------------------------------------------------------------------
// ntfd_varint: one LEB128 accumulation step with a bit-width bound
// Folds seven value bits into the running value and flags overflow.
// ----------------------------------------------------------------------------
module ntfd_varint
  import ntfd_pkg::*;
#(
  parameter int VW = 32,
  parameter int SW = 6
) (
  input  logic [7:0]    byte_value,
  input  logic [VW-1:0] value,
  input  logic [SW-1:0] shift,
  input  logic [SW-1:0] bits,
  output logic [VW-1:0] value_nxt,
  output logic [SW-1:0] shift_nxt,
  output logic          ovf
);

  logic [6:0]    chunk;
  logic [SW-1:0] room;
  logic [6:0]    hi;

  assign chunk = byte_value[6:0];
  assign room  = bits - shift;
  assign hi    = chunk >> room;

  always_comb begin
    value_nxt = value;
    shift_nxt = shift;
    ovf       = 1'b0;
    if (shift >= bits) begin
      // past the bound: only zero padding allowed
      ovf = (chunk != 7'd0);
    end else begin
      ovf       = (room < SW'(7)) && (hi != 7'd0);
      value_nxt = value | ({{(VW-7){1'b0}}, chunk} << shift);
      shift_nxt = shift + SW'(7);
    end
  end

endmodule

[src/nested_tlv_frame_detector.sv]
// ----------------------------------------------------------------------------
// nested_tlv_frame_detector: LEB128 TLV deframer with nested nodes
// Parses a byte stream of nested nodes, tracks open child counts in a stack
// memory and reports the byte count of each completed top-level frame, or an
// error status after which the parser halts until restart.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | item type   | direction
//  --------+------------------------------+-------------+----------
//  input   | in_valid, in_stall, in_item  | in_item_t   | in
//  result  | out_valid, out_stall,out_item| out_item_t  | out
//
//  After a byte that gives no result and reads no stack level, the input
//  is taken again on the next cycle. A byte that gives a result stalls the
//  input until it is moved into the output register, which out_stall holds.
//  A node end that empties the top stack level reads the next level back
//  from the stack memory, level by level, until a level that
//  still owes children is found or the frame ends.
//  Reset (rst_n low, synchronous) clears the parser; the stack memory needs
//  no clearing pass, since only entries below the current level are read.
//  The output register lets the next byte be taken while a result waits.
//
module nested_tlv_frame_detector
  import ntfd_pkg::*;
#(
  parameter int NEST_DEPTH = 64,
  parameter int LEN_BITS   = 32,
  parameter int CHILD_BITS = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // varint value must hold either bound; shift counter runs up to VW+6
  localparam int VW = (LEN_BITS > CHILD_BITS) ? LEN_BITS : CHILD_BITS;
  localparam int SW = $clog2(VW + 8);
  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int AW = $clog2(NEST_DEPTH);

  ctl_t                  ctl_r, ctl_nxt;
  phase_t                phase_r, phase_nxt;
  logic [VW-1:0]         vval_r, vval_nxt;
  logic [SW-1:0]         vshift_r, vshift_nxt;
  logic                  vfield_r, vfield_nxt;
  logic [LEN_BITS-1:0]   pay_r, pay_nxt;
  logic [LW-1:0]         level_r, level_nxt;
  logic [CHILD_BITS-1:0] top_r, top_nxt;     // count of the open top level
  logic [31:0]           fcount_r, fcount_nxt;
  out_item_t             res_r, res_nxt;     // result waiting for hand-off
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic                  in_acc;
  logic                  out_free;
  phase_t                eff_phase;
  logic [LW-1:0]         eff_level;
  logic [31:0]           eff_fcount;
  logic [31:0]           fc_inc;
  logic [LW-1:0]         lvl_m1;
  logic [LW-1:0]         lvl_m2;
  logic [LW-1:0]         pop_m1;
  logic [LW-1:0]         pop_m2;

  logic [SW-1:0]         vbits;
  logic [VW-1:0]         vv_nxt;
  logic [SW-1:0]         vs_nxt;
  logic                  v_ovf;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [CHILD_BITS-1:0] mem_rdata;

  logic                  node_end;
  logic                  fail;
  status_t               fail_st;

  assign in_stall  = (ctl_r != CTL_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // restart clears the parser ahead of the byte it arrives with
  assign eff_phase  = in_item.restart ? PH_TAG : phase_r;
  assign eff_level  = in_item.restart ? '0 : level_r;
  assign eff_fcount = in_item.restart ? 32'd0 : fcount_r;
  assign fc_inc     = (eff_fcount == FRAME_MAX) ? FRAME_MAX : eff_fcount + 32'd1;
  assign lvl_m1     = eff_level - LW'(1);
  assign lvl_m2     = eff_level - LW'(2);
  assign pop_m1     = level_r - LW'(1);
  assign pop_m2     = level_r - LW'(2);

  // child count is bounded by CHILD_BITS, id and length by LEN_BITS
  assign vbits = (phase_r == PH_COMP && vfield_r) ? SW'(CHILD_BITS) : SW'(LEN_BITS);

  ntfd_varint #(
    .VW (VW),
    .SW (SW)
  ) u_varint (
    .byte_value (in_item.byte_value),
    .value      (vval_r),
    .shift      (vshift_r),
    .bits       (vbits),
    .value_nxt  (vv_nxt),
    .shift_nxt  (vs_nxt),
    .ovf        (v_ovf)
  );

  // stack of remaining child counts below the top level
  ntfd_ram #(
    .WIDTH (CHILD_BITS),
    .DEPTH (NEST_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (top_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    ctl_nxt    = ctl_r;
    phase_nxt  = phase_r;
    vval_nxt   = vval_r;
    vshift_nxt = vshift_r;
    vfield_nxt = vfield_r;
    pay_nxt    = pay_r;
    level_nxt  = level_r;
    top_nxt    = top_r;
    fcount_nxt = fcount_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    node_end   = 1'b0;
    fail       = 1'b0;
    fail_st    = ST_DONE;

    unique case (ctl_r)
      CTL_IDLE: begin
        if (in_acc) begin
          phase_nxt  = eff_phase;
          level_nxt  = eff_level;
          fcount_nxt = eff_fcount;
          if (eff_phase != PH_HALT) begin
            fcount_nxt = fc_inc;
          end

          unique case (eff_phase)
            PH_TAG: begin
              vval_nxt   = '0;
              vshift_nxt = '0;
              if (in_item.byte_value == TAG_BLOB || in_item.byte_value == TAG_TEXT ||
                  in_item.byte_value == TAG_NUMBER) begin
                phase_nxt = PH_LEN;
              end else if (in_item.byte_value == TAG_NODE) begin
                phase_nxt  = PH_COMP;
                vfield_nxt = 1'b0;
              end else begin
                fail    = 1'b1;
                fail_st = ST_BADTAG;
              end
            end
            PH_LEN: begin
              vval_nxt   = vv_nxt;
              vshift_nxt = vs_nxt;
              if (v_ovf) begin
                fail    = 1'b1;
                fail_st = ST_LONG;
              end else if ((in_item.byte_value & VARINT_MORE) == '0) begin
                if (vv_nxt == '0) begin
                  node_end = 1'b1;
                end else begin
                  pay_nxt   = vv_nxt[LEN_BITS-1:0];
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              pay_nxt = pay_r - LEN_BITS'(1);
              if (pay_r == LEN_BITS'(1)) begin
                node_end = 1'b1;
              end
            end
            PH_COMP: begin
              vval_nxt   = vv_nxt;
              vshift_nxt = vs_nxt;
              if (v_ovf) begin
                fail    = 1'b1;
                fail_st = ST_LONG;
              end else if ((in_item.byte_value & VARINT_MORE) == '0) begin
                if (!vfield_r) begin
                  // id done, child count follows
                  vfield_nxt = 1'b1;
                  vval_nxt   = '0;
                  vshift_nxt = '0;
                end else begin
                  vfield_nxt = 1'b0;
                  if (vv_nxt == '0) begin
                    node_end = 1'b1;
                  end else if (eff_level >= LW'(NEST_DEPTH)) begin
                    fail    = 1'b1;
                    fail_st = ST_DEEP;
                  end else begin
                    // push: spill the old top into the stack memory
                    mem_we    = (eff_level != '0);
                    mem_waddr = lvl_m1[AW-1:0];
                    top_nxt   = vv_nxt[CHILD_BITS-1:0];
                    level_nxt = eff_level + LW'(1);
                    phase_nxt = PH_TAG;
                  end
                end
              end
            end
            PH_HALT: begin
            end
            default: begin
              phase_nxt = PH_HALT;
            end
          endcase

          if (fail) begin
            phase_nxt = PH_HALT;
            res_nxt   = '{status: fail_st, frame_bytes: fc_inc};
            ctl_nxt   = CTL_EMIT;
          end

          if (node_end) begin
            phase_nxt = PH_TAG;
            if (eff_level == '0) begin
              res_nxt    = '{status: ST_DONE, frame_bytes: fc_inc};
              fcount_nxt = 32'd0;
              ctl_nxt    = CTL_EMIT;
            end else if (top_r > CHILD_BITS'(1)) begin
              top_nxt = top_r - CHILD_BITS'(1);
            end else begin
              level_nxt = lvl_m1;
              if (eff_level == LW'(1)) begin
                res_nxt    = '{status: ST_DONE, frame_bytes: fc_inc};
                fcount_nxt = 32'd0;
                ctl_nxt    = CTL_EMIT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = lvl_m2[AW-1:0];
                ctl_nxt   = CTL_POP;
              end
            end
          end
        end
      end

      CTL_POP: begin
        // mem_rdata is the new top level's count
        if (mem_rdata > CHILD_BITS'(1)) begin
          top_nxt = mem_rdata - CHILD_BITS'(1);
          ctl_nxt = CTL_IDLE;
        end else begin
          level_nxt = pop_m1;
          if (level_r == LW'(1)) begin
            res_nxt    = '{status: ST_DONE, frame_bytes: fcount_r};
            fcount_nxt = 32'd0;
            ctl_nxt    = CTL_EMIT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pop_m2[AW-1:0];
          end
        end
      end

      CTL_EMIT: begin
        if (out_free) begin
          ctl_nxt = CTL_IDLE;
        end
      end

      default: begin
        ctl_nxt = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= CTL_IDLE;
      phase_r  <= PH_TAG;
      vval_r   <= '0;
      vshift_r <= '0;
      vfield_r <= 1'b0;
      pay_r    <= '0;
      level_r  <= '0;
      fcount_r <= 32'd0;
    end else begin
      ctl_r    <= ctl_nxt;
      phase_r  <= phase_nxt;
      vval_r   <= vval_nxt;
      vshift_r <= vshift_nxt;
      vfield_r <= vfield_nxt;
      pay_r    <= pay_nxt;
      level_r  <= level_nxt;
      fcount_r <= fcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    res_r <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_r == CTL_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_r == CTL_EMIT && out_free) begin
      out_item_r <= res_r;
    end
  end

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(NEST_DEPTH))
    else $error("stack level beyond nesting depth");

  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r == CTL_POP |-> level_r >= LW'(1))
    else $error("stack pop with no open level");

  a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CTL_EMIT && res_r.status == ST_DONE) |-> fcount_r == 32'd0)
    else $error("frame byte count not cleared after a completed frame");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> pay_r != '0)
    else $error("payload phase with no bytes left");

  a_fail_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r == CTL_EMIT && res_r.status != ST_DONE) |-> phase_r == PH_HALT)
    else $error("error result without halting the parser");

endmodule
